FILE: hdl/fixts_pkg.sv
package fixts_pkg;

    typedef enum logic [1:0] {
        S_COLLECT,
        S_DAYS,
        S_SECS,
        S_MICRO
    } t_state;

    typedef enum logic [3:0] {
        E_OK         = 4'd0,
        E_SHORT      = 4'd1,
        E_DATE_DIGIT = 4'd2,
        E_YEAR       = 4'd3,
        E_MONTH      = 4'd4,
        E_DAY        = 4'd5,
        E_DASH       = 4'd6,
        E_TIME_DIGIT = 4'd7,
        E_HOUR       = 4'd8,
        E_MINUTE     = 4'd9,
        E_SECOND     = 4'd10,
        E_COLONS     = 4'd11,
        E_CALENDAR   = 4'd12
    } t_err;

    typedef struct packed {
        logic take_char;
        logic convert;
        logic scale_secs;
        logic scale_micros;
    } t_cmd;

    localparam int FLAG_DATE_DIGIT = 0;
    localparam int FLAG_DASH       = 1;
    localparam int FLAG_TIME_DIGIT = 2;
    localparam int FLAG_COLON      = 3;

    localparam logic [4:0]  MIN_LEN = 5'd17;
    localparam logic [4:0]  POS_MAX = 5'd31;
    localparam logic [13:0] YEAR_LO = 14'd1900;
    localparam logic [13:0] YEAR_HI = 14'd2100;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    function automatic logic [4:0] month_days(input logic [6:0] month, input logic leap);
        logic [4:0] d;
        unique case (month)
            7'd2:                         d = leap ? 5'd29 : 5'd28;
            7'd4, 7'd6, 7'd9, 7'd11:      d = 5'd30;
            default:                      d = 5'd31;
        endcase
        return d;
    endfunction

    // days from March 1 to the first of the month, March-based year
    function automatic logic [8:0] month_offset(input logic [6:0] month);
        logic [8:0] o;
        unique case (month)
            7'd1:    o = 9'd306;
            7'd2:    o = 9'd337;
            7'd3:    o = 9'd0;
            7'd4:    o = 9'd31;
            7'd5:    o = 9'd61;
            7'd6:    o = 9'd92;
            7'd7:    o = 9'd122;
            7'd8:    o = 9'd153;
            7'd9:    o = 9'd184;
            7'd10:   o = 9'd214;
            7'd11:   o = 9'd245;
            7'd12:   o = 9'd275;
            default: o = 9'd0;
        endcase
        return o;
    endfunction

endpackage

FILE: hdl/fixts_ctrl.sv
module fixts_ctrl
    import fixts_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_char_present,
    input  logic i_last_char,
    input  logic i_stall,
    output logic o_stall,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_accept;
    logic   w_load;

    assign w_accept = i_valid && (r_state == S_COLLECT);
    // output register free now or emptied at this edge
    assign w_load   = (r_state == S_MICRO) && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_COLLECT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_COLLECT: begin
                if (w_accept && i_last_char) begin
                    n_state = S_DAYS;
                end
            end
            S_DAYS:  n_state = S_SECS;
            S_SECS:  n_state = S_MICRO;
            S_MICRO: begin
                if (w_load) begin
                    n_state = S_COLLECT;
                end
            end
            default: n_state = S_COLLECT;
        endcase

        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_comb begin
        o_stall              = (r_state != S_COLLECT);
        o_valid              = r_out_valid;
        o_cmd.take_char      = w_accept && i_char_present;
        o_cmd.convert        = (r_state == S_DAYS);
        o_cmd.scale_secs     = (r_state == S_SECS);
        o_cmd.scale_micros   = w_load;
    end

endmodule

FILE: hdl/fixts_datapath.sv
module fixts_datapath
    import fixts_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [7:0]         i_char_code,
    output logic signed [52:0] o_epoch_micros,
    output logic               o_ok,
    output logic [3:0]         o_error_code
);

    logic [4:0]  r_pos;
    logic [13:0] r_year;
    logic [6:0]  r_month, r_day, r_hour, r_minute, r_second;
    logic [9:0]  r_millis;
    logic [1:0]  r_frac_n;
    logic        r_frac_open;
    logic [3:0]  r_flags;

    logic [4:0]  n_pos;
    logic [13:0] n_year;
    logic [6:0]  n_month, n_day, n_hour, n_minute, n_second;
    logic [9:0]  n_millis;
    logic [1:0]  n_frac_n;
    logic        n_frac_open;
    logic [3:0]  n_flags;

    logic signed [16:0] r_days;
    logic [16:0]        r_tod;
    logic [19:0]        r_msu;
    t_err               r_err;
    logic signed [33:0] r_secs;

    logic        w_isd;
    logic [3:0]  w_dig;

    function automatic logic [6:0] acc7(input logic [6:0] a, input logic [3:0] d);
        return 7'(a * 7'd10 + {3'd0, d});
    endfunction

    assign w_isd = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
    assign w_dig = w_isd ? i_char_code[3:0] : 4'd0;

    always_comb begin
        n_pos       = r_pos;
        n_year      = r_year;
        n_month     = r_month;
        n_day       = r_day;
        n_hour      = r_hour;
        n_minute    = r_minute;
        n_second    = r_second;
        n_millis    = r_millis;
        n_frac_n    = r_frac_n;
        n_frac_open = r_frac_open;
        n_flags     = r_flags;
        if (i_cmd.convert) begin
            n_pos       = '0;
            n_year      = '0;
            n_month     = '0;
            n_day       = '0;
            n_hour      = '0;
            n_minute    = '0;
            n_second    = '0;
            n_millis    = '0;
            n_frac_n    = '0;
            n_frac_open = 1'b0;
            n_flags     = '0;
        end else if (i_cmd.take_char) begin
            if (r_pos <= 5'd3) begin
                n_year = 14'(r_year * 14'd10 + {10'd0, w_dig});
                if (!w_isd) n_flags[FLAG_DATE_DIGIT] = 1'b1;
            end else if (r_pos <= 5'd5) begin
                n_month = acc7(r_month, w_dig);
                if (!w_isd) n_flags[FLAG_DATE_DIGIT] = 1'b1;
            end else if (r_pos <= 5'd7) begin
                n_day = acc7(r_day, w_dig);
                if (!w_isd) n_flags[FLAG_DATE_DIGIT] = 1'b1;
            end else if (r_pos == 5'd8) begin
                if (i_char_code != CH_DASH) n_flags[FLAG_DASH] = 1'b1;
            end else if (r_pos <= 5'd10) begin
                n_hour = acc7(r_hour, w_dig);
                if (!w_isd) n_flags[FLAG_TIME_DIGIT] = 1'b1;
            end else if (r_pos == 5'd11 || r_pos == 5'd14) begin
                if (i_char_code != CH_COLON) n_flags[FLAG_COLON] = 1'b1;
            end else if (r_pos <= 5'd13) begin
                n_minute = acc7(r_minute, w_dig);
                if (!w_isd) n_flags[FLAG_TIME_DIGIT] = 1'b1;
            end else if (r_pos <= 5'd16) begin
                n_second = acc7(r_second, w_dig);
                if (!w_isd) n_flags[FLAG_TIME_DIGIT] = 1'b1;
            end else if (r_pos == 5'd17) begin
                n_frac_open = (i_char_code == CH_DOT);
            end else if (r_pos <= 5'd20) begin
                if (r_frac_open && w_isd) begin
                    n_millis = 10'(r_millis * 10'd10 + {6'd0, w_dig});
                    n_frac_n = r_frac_n + 2'd1;
                end else begin
                    n_frac_open = 1'b0;
                end
            end
            if (r_pos < POS_MAX) n_pos = r_pos + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_year      <= '0;
            r_month     <= '0;
            r_day       <= '0;
            r_hour      <= '0;
            r_minute    <= '0;
            r_second    <= '0;
            r_millis    <= '0;
            r_frac_n    <= '0;
            r_frac_open <= 1'b0;
            r_flags     <= '0;
        end else begin
            r_pos       <= n_pos;
            r_year      <= n_year;
            r_month     <= n_month;
            r_day       <= n_day;
            r_hour      <= n_hour;
            r_minute    <= n_minute;
            r_second    <= n_second;
            r_millis    <= n_millis;
            r_frac_n    <= n_frac_n;
            r_frac_open <= n_frac_open;
            r_flags     <= n_flags;
        end
    end

    // error judgment, day count, time of day and fraction scale from the finished fields
    logic               w_leap;
    t_err               w_err;
    logic [13:0]        w_yy;
    logic               w_era5;
    logic [8:0]         w_yoe;
    logic [1:0]         w_c100;
    logic [17:0]        w_doe;
    logic signed [18:0] w_era_term;
    logic signed [18:0] w_days;
    logic [16:0]        w_tod;
    logic [19:0]        w_scale;

    always_comb begin
        w_leap = (r_year[1:0] == 2'b00) && (r_year != 14'd1900) && (r_year != 14'd2100);
        priority if (r_pos < MIN_LEN)                                w_err = E_SHORT;
        else if (r_flags[FLAG_DATE_DIGIT])                           w_err = E_DATE_DIGIT;
        else if (r_year < YEAR_LO || r_year > YEAR_HI)               w_err = E_YEAR;
        else if (r_month < 7'd1 || r_month > 7'd12)                  w_err = E_MONTH;
        else if (r_day < 7'd1 || r_day > 7'd31)                      w_err = E_DAY;
        else if (r_flags[FLAG_DASH])                                 w_err = E_DASH;
        else if (r_flags[FLAG_TIME_DIGIT])                           w_err = E_TIME_DIGIT;
        else if (r_hour > 7'd23)                                     w_err = E_HOUR;
        else if (r_minute > 7'd59)                                   w_err = E_MINUTE;
        else if (r_second > 7'd59)                                   w_err = E_SECOND;
        else if (r_flags[FLAG_COLON])                                w_err = E_COLONS;
        else if (r_day > {2'b00, month_days(r_month, w_leap)})       w_err = E_CALENDAR;
        else                                                         w_err = E_OK;

        w_yy   = r_year - ((r_month <= 7'd2) ? 14'd1 : 14'd0);
        w_era5 = (w_yy >= 14'd2000);
        w_yoe  = 9'(w_yy - (w_era5 ? 14'd2000 : 14'd1600));
        priority if (w_yoe >= 9'd300) w_c100 = 2'd3;
        else if (w_yoe >= 9'd200)     w_c100 = 2'd2;
        else if (w_yoe >= 9'd100)     w_c100 = 2'd1;
        else                          w_c100 = 2'd0;
        w_doe = 18'(w_yoe * 18'd365) + {11'd0, w_yoe[8:2]} - {16'd0, w_c100}
              + {9'd0, month_offset(r_month)} + {11'd0, r_day} - 18'd1;
        // era * 146097 - 719468 for era 5 or 4
        w_era_term = w_era5 ? 19'sd11017 : -19'sd135080;
        w_days     = $signed({1'b0, w_doe}) + w_era_term;

        w_tod = 17'(r_hour * 17'd3600) + 17'(r_minute * 17'd60) + {10'd0, r_second};
        unique case (r_frac_n)
            2'd1:    w_scale = 20'd100000;
            2'd2:    w_scale = 20'd10000;
            2'd3:    w_scale = 20'd1000;
            default: w_scale = 20'd0;
        endcase
    end

    logic signed [47:0] w_scaled;
    logic signed [52:0] w_micros;

    assign w_scaled = $signed(48'(r_secs * $signed(15'sd15625)));
    assign w_micros = $signed({w_scaled[46:0], 6'b0}) + $signed({33'd0, r_msu});

    always_ff @(posedge i_clk) begin
        if (i_cmd.convert) begin
            r_days <= w_days[16:0];
            r_tod  <= w_tod;
            r_msu  <= 20'(r_millis * w_scale);
            r_err  <= w_err;
        end
        if (i_cmd.scale_secs) begin
            r_secs <= $signed(34'(r_days * $signed(18'sd86400))) + $signed({17'd0, r_tod});
        end
        if (i_cmd.scale_micros) begin
            o_epoch_micros <= (r_err == E_OK) ? w_micros : '0;
            o_ok           <= (r_err == E_OK);
            o_error_code   <= r_err;
        end
    end

endmodule

FILE: hdl/fix_timestamp_to_epoch_micros.sv
// Conversion: once the item marked last is taken, the convert step registers the
// day count, time of day and fraction, the seconds step scales the day count and
// adds the time of day, and the microsecond step loads the output register.
// Throughput: one character item per cycle while a string is collected; after the
// last item the three-step epoch conversion holds off input until its last step,
// which waits while the previous result is still held, has loaded the output.
// Reset: synchronous active-low; clears all field accumulators and the controller.
module fix_timestamp_to_epoch_micros
    import fixts_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_char_code,
    input  logic               i_char_present,
    input  logic               i_last_char,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [52:0] o_epoch_micros,
    output logic               o_ok,
    output logic [3:0]         o_error_code
);

    t_cmd w_cmd;

    fixts_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_char_present (i_char_present),
        .i_last_char    (i_last_char),
        .i_stall        (i_stall),
        .o_stall        (o_stall),
        .o_valid        (o_valid),
        .o_cmd          (w_cmd)
    );

    fixts_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_char_code    (i_char_code),
        .o_epoch_micros (o_epoch_micros),
        .o_ok           (o_ok),
        .o_error_code   (o_error_code)
    );

endmodule

FILE: test/tb_fix_timestamp_to_epoch_micros.sv
module tb_fix_timestamp_to_epoch_micros
    import fixts_pkg::*;
();

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [7:0]         i_char_code;
    logic               i_char_present;
    logic               i_last_char;
    logic               o_valid;
    logic               i_stall;
    logic signed [52:0] o_epoch_micros;
    logic               o_ok;
    logic [3:0]         o_error_code;

    typedef struct {
        logic signed [52:0] epoch;
        logic               ok;
        t_err               code;
    } t_stamp_result;

    class epoch_checker;
        bit [4:0]      position;
        bit [13:0]     year;
        bit [6:0]      month, day, hour, minute, second;
        bit [9:0]      millis;
        bit [1:0]      frac_count;
        bit            frac_open;
        bit [3:0]      flags;
        t_stamp_result pending_stamps[$];
        int            mismatches;

        function new();
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            position = 0;
            year = 0;
            month = 0;
            day = 0;
            hour = 0;
            minute = 0;
            second = 0;
            millis = 0;
            frac_count = 0;
            frac_open = 0;
            flags = 0;
        endfunction

        function int pending();
            return pending_stamps.size();
        endfunction

        function int digit_of(bit [7:0] c, int flag);
            if (c >= CH_ZERO && c <= CH_NINE) begin
                return c - CH_ZERO;
            end
            flags[flag] = 1'b1;
            return 0;
        endfunction

        function int month_length(int y, int m);
            bit leap;
            leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
            case (m)
                2: begin
                    return leap ? 29 : 28;
                end
                4, 6, 9, 11: begin
                    return 30;
                end
                default: begin
                    return 31;
                end
            endcase
        endfunction

        // civil date to day count, years counted from March
        function longint day_number(int y, int m, int d);
            int yy, era, yoe, mp, doy, doe;
            yy = (m <= 2) ? y - 1 : y;
            era = yy / 400;
            yoe = yy - era * 400;
            mp = (m > 2) ? m - 3 : m + 9;
            doy = (153 * mp + 2) / 5 + d - 1;
            doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            return longint'(era) * 146097 + doe - 719468;
        endfunction

        function t_err judge();
            if (position < MIN_LEN) return E_SHORT;
            if (flags[FLAG_DATE_DIGIT]) return E_DATE_DIGIT;
            if (year < YEAR_LO || year > YEAR_HI) return E_YEAR;
            if (month < 1 || month > 12) return E_MONTH;
            if (day < 1 || day > 31) return E_DAY;
            if (flags[FLAG_DASH]) return E_DASH;
            if (flags[FLAG_TIME_DIGIT]) return E_TIME_DIGIT;
            if (hour > 23) return E_HOUR;
            if (minute > 59) return E_MINUTE;
            if (second > 59) return E_SECOND;
            if (flags[FLAG_COLON]) return E_COLONS;
            if (day > month_length(year, month)) return E_CALENDAR;
            return E_OK;
        endfunction

        function void take_char(bit [7:0] c, bit present, bit last);
            t_stamp_result r;
            longint        micros;
            int            ms;
            if (present) begin
                if (position <= 3) begin
                    year = 14'(year * 10 + digit_of(c, FLAG_DATE_DIGIT));
                end else if (position <= 5) begin
                    month = 7'(month * 10 + digit_of(c, FLAG_DATE_DIGIT));
                end else if (position <= 7) begin
                    day = 7'(day * 10 + digit_of(c, FLAG_DATE_DIGIT));
                end else if (position == 8) begin
                    if (c != CH_DASH) flags[FLAG_DASH] = 1'b1;
                end else if (position <= 10) begin
                    hour = 7'(hour * 10 + digit_of(c, FLAG_TIME_DIGIT));
                end else if (position == 11 || position == 14) begin
                    if (c != CH_COLON) flags[FLAG_COLON] = 1'b1;
                end else if (position <= 13) begin
                    minute = 7'(minute * 10 + digit_of(c, FLAG_TIME_DIGIT));
                end else if (position <= 16) begin
                    second = 7'(second * 10 + digit_of(c, FLAG_TIME_DIGIT));
                end else if (position == 17) begin
                    frac_open = (c == CH_DOT);
                end else if (position <= 20) begin
                    if (frac_open && c >= CH_ZERO && c <= CH_NINE) begin
                        millis = 10'(millis * 10 + (c - CH_ZERO));
                        frac_count = frac_count + 2'd1;
                    end else begin
                        frac_open = 1'b0;
                    end
                end
                if (position != POS_MAX) position = position + 5'd1;
            end
            if (last) begin
                r.code = judge();
                r.ok = (r.code == E_OK);
                r.epoch = '0;
                if (r.ok) begin
                    ms = millis;
                    for (int n = frac_count; n < 3; n++) ms = ms * 10;
                    micros = day_number(year, month, day) * 64'sd86400000000
                           + longint'(hour) * 64'sd3600000000
                           + longint'(minute) * 64'sd60000000
                           + longint'(second) * 64'sd1000000
                           + longint'(ms) * 64'sd1000;
                    r.epoch = micros[52:0];
                end
                pending_stamps.insert(pending_stamps.size(), r);
                clear();
            end
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            mismatches++;
        endtask

        task check_stamp(logic signed [52:0] epoch, logic ok, logic [3:0] code);
            t_stamp_result e;
            if (pending_stamps.size() == 0) begin
                report("result with no string pending");
                return;
            end
            e = pending_stamps.pop_front();
            if (epoch !== e.epoch) begin
                report($sformatf("epoch_micros %0d, want %0d", epoch, e.epoch));
            end
            if (ok !== e.ok) begin
                report($sformatf("ok %b, want %b", ok, e.ok));
            end
            if (code !== e.code) begin
                report($sformatf("error_code %0d, want %0d", code, e.code));
            end
        endtask
    endclass

    epoch_checker sb = new();
    int           cycle_count = 0;
    int           burst_left = 0;
    int           literal_items = 0;
    bit           hold_req = 1'b0;

    fix_timestamp_to_epoch_micros dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_char_code    (i_char_code),
        .i_char_present (i_char_present),
        .i_last_char    (i_last_char),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_epoch_micros (o_epoch_micros),
        .o_ok           (o_ok),
        .o_error_code   (o_error_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // outputs and stall are stable at the falling edge; an item seen here is taken
    // at the next rising edge
    initial begin
        forever begin
            @(negedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                sb.check_stamp(o_epoch_micros, o_ok, o_error_code);
            end
        end
    end

    initial begin
        int pct, run;
        i_stall <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                case ($urandom_range(4))
                    0, 1: pct = 0;
                    2: pct = 30;
                    3: pct = 70;
                    default: pct = 95;
                endcase
                run = $urandom_range(1, 50);
                repeat (run) begin
                    if (hold_req) break;
                    i_stall <= ($urandom_range(99) < pct);
                    @(posedge i_clk);
                end
            end
        end
    end

    task automatic send_item(input bit [7:0] c, input bit present, input bit last);
        bit taken;
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_char_code <= c;
        i_char_present <= present;
        i_last_char <= last;
        i_valid <= 1'b1;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
        sb.take_char(c, present, last);
    endtask

    task automatic send_bytes(input bit [7:0] text[$], input bit blank_end, output int n);
        n = 0;
        foreach (text[i]) begin
            if ($urandom_range(19) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            send_item(text[i], 1'b1, !blank_end && i == text.size() - 1);
            n++;
        end
        if (blank_end || text.size() == 0) begin
            send_item(8'($urandom_range(255)), 1'b0, 1'b1);
            n++;
        end
    endtask

    task automatic send_literal(input string s, input bit blank_end = 1'b0);
        bit [7:0] text[$];
        int       n;
        for (int i = 0; i < s.len(); i++) text.insert(text.size(), s[i]);
        send_bytes(text, blank_end, n);
        literal_items += n;
    endtask

    task automatic send_random_stamp(output int n);
        string    s;
        bit [7:0] text[$];
        int       y, mo, d, hh, mi, ss, len;
        if ($urandom_range(99) < 8) begin
            len = $urandom_range(0, 34);
            repeat (len) begin
                text.insert(text.size(), 8'(($urandom_range(3) == 0) ? $urandom_range(255)
                                            : $urandom_range(8'h2D, 8'h3A)));
            end
        end else begin
            y = ($urandom_range(9) != 0) ? $urandom_range(1900, 2100) : $urandom_range(9999);
            mo = ($urandom_range(9) != 0) ? $urandom_range(1, 12) : $urandom_range(99);
            case ($urandom_range(9))
                0: d = $urandom_range(99);
                1, 2: d = $urandom_range(28, 31);
                default: begin
                    d = (mo >= 1 && mo <= 12) ? $urandom_range(1, sb.month_length(y, mo))
                                              : $urandom_range(1, 31);
                end
            endcase
            hh = ($urandom_range(9) != 0) ? $urandom_range(23) : $urandom_range(99);
            mi = ($urandom_range(9) != 0) ? $urandom_range(59) : $urandom_range(99);
            ss = ($urandom_range(9) != 0) ? $urandom_range(59) : $urandom_range(99);
            s = $sformatf("%04d%02d%02d-%02d:%02d:%02d", y, mo, d, hh, mi, ss);
            if ($urandom_range(2) != 0) begin
                s = {s, "."};
                repeat ($urandom_range(3)) s = {s, $sformatf("%0d", $urandom_range(9))};
            end
            for (int i = 0; i < s.len(); i++) text.insert(text.size(), s[i]);
            if ($urandom_range(5) == 0) begin
                repeat ($urandom_range(1, 16)) text.insert(text.size(), 8'($urandom_range(255)));
            end
            if ($urandom_range(6) == 0) begin
                text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
            end
            if ($urandom_range(15) == 0) begin
                len = $urandom_range(16);
                while (text.size() > len) void'(text.pop_back());
            end
        end
        send_bytes(text, $urandom_range(7) == 0, n);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        int sent, n;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_char_code <= 8'h00;
        i_char_present <= 1'b0;
        i_last_char <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_literal("20240229-23:59:59.999");
        send_literal("19000101-00:00:00");
        send_literal("21001231-23:59:59.999");
        send_literal("20000229-12:34:56.5");
        send_literal("", 1'b1);
        send_literal("20240101-12:00:0");
        send_literal("2024a101-12:00:00");
        send_literal("18991231-23:59:59");
        send_literal("21010101-00:00:00");
        send_literal("20241301-00:00:00");
        send_literal("20240100-00:00:00");
        send_literal("20240132-00:00:00");
        send_literal("20240101 12:00:00");
        send_literal("20240101-1x:00:00");
        send_literal("20240101-24:00:00");
        send_literal("20240101-23:60:00");
        send_literal("20240101-23:59:60");
        send_literal("20240101-12.00:00");
        send_literal("19000229-00:00:00");
        send_literal("20230431-00:00:00");
        send_literal("20240101-00:00:00.12");
        send_literal("20240101-00:00:00x123");
        send_literal("20240101-00:00:00.1a9");
        send_literal("19700101-00:00:00.", 1'b1);
        send_literal("19691231-23:59:59.001-trailing-chars-past-31");
        wait_idle();

        sent = literal_items;
        while (sent < 600) begin
            send_random_stamp(n);
            sent += n;
        end
        wait_idle();

        hold_req = 1'b1;
        repeat (6) begin
            send_random_stamp(n);
            sent += n;
        end
        wait_idle();

        while (sent < 1000) begin
            send_random_stamp(n);
            sent += n;
        end
        wait_idle();

        if (sb.pending() != 0) sb.report("results missing at end");
        if (sb.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/fixts_pkg.sv
hdl/fixts_ctrl.sv
hdl/fixts_datapath.sv
hdl/fix_timestamp_to_epoch_micros.sv
test/tb_fix_timestamp_to_epoch_micros.sv
